FILE: hw/rtl/icu_pkg.sv
package icu_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int REQ_TYPE_W = 3;
    localparam int DIV_CNT_W  = $clog2(DATA_WIDTH);

    typedef enum logic [REQ_TYPE_W-1:0] {
        OP_ADD   = 3'd0,
        OP_SUB   = 3'd1,
        OP_MUL   = 3'd2,
        OP_POW   = 3'd3,
        OP_ABS   = 3'd4,
        OP_PRIME = 3'd5
    } op_t;

endpackage

FILE: hw/rtl/icu_req_if.sv
interface icu_req_if;
    logic                                    valid;
    logic                                    ready;
    logic        [icu_pkg::REQ_TYPE_W-1:0]   req_type;
    logic signed [icu_pkg::DATA_WIDTH-1:0]   operand_a;
    logic signed [icu_pkg::DATA_WIDTH-1:0]   operand_b;

    modport source (output valid, req_type, operand_a, operand_b, input ready);
    modport sink   (input valid, req_type, operand_a, operand_b, output ready);
endinterface

FILE: hw/rtl/icu_rsp_if.sv
interface icu_rsp_if;
    logic                                    valid;
    logic                                    ready;
    logic signed [icu_pkg::DATA_WIDTH-1:0]   answer;

    modport source (output valid, answer, input ready);
    modport sink   (input valid, answer, output ready);
endinterface

FILE: hw/rtl/integer_calculator_unit.sv
// Integer calculator: one request beat (operation, two signed operands) gives
// exactly one answer beat. Add, subtract, absolute value and unused codes
// are computed at acceptance; multiply goes through the S_MUL state. Power
// runs square-and-multiply on the single shared 32x32 multiplier, alternating
// accumulate and square states for each exponent bit up to the highest set
// bit. Prime test does trial division on a one-bit-per-cycle divider with up
// to about sqrt(a) trial divisors. One request is in work at a time: ready is
// high only while the sequencer is idle. A finished answer waits in an output
// register, so the next request may be taken while the previous answer is
// still unclaimed.
module integer_calculator_unit (
    input  logic       clk,
    input  logic       rst_n,
    icu_req_if.sink    req,
    icu_rsp_if.source  rsp
);
    import icu_pkg::*;

    localparam int W = DATA_WIDTH;

    typedef enum logic [6:0] {
        S_IDLE      = 7'b0000001,
        S_MUL       = 7'b0000010,
        S_POW_ACC   = 7'b0000100,
        S_POW_SQR   = 7'b0001000,
        S_DIV_START = 7'b0010000,
        S_DIV_WAIT  = 7'b0100000,
        S_DONE      = 7'b1000000
    } state_t;

    state_t       state_reg, state_next;
    logic [W-1:0] opa_reg, opa_next;     // operand a, power base, tested value
    logic [W-1:0] opb_reg, opb_next;     // operand b, exponent, trial divisor
    logic [W-1:0] res_reg, res_next;     // result, power accumulator
    logic         out_valid_reg, out_valid_next;
    logic [W-1:0] out_data_reg, out_data_next;

    logic [W-1:0] a_in, b_in;
    logic [W-1:0] mul_x, mul_y, mul_p;
    logic         div_start;
    logic         div_done;
    logic [W-1:0] div_quo, div_rem;
    logic         accept, load_out;

    assign a_in   = req.operand_a;
    assign b_in   = req.operand_b;
    assign accept = req.valid && req.ready;

    // shared multiplier, low half only (wraps modulo 2^W)
    assign mul_x = (state_reg == S_POW_ACC) ? res_reg : opa_reg;
    assign mul_y = (state_reg == S_MUL) ? opb_reg : opa_reg;
    assign mul_p = mul_x * mul_y;

    assign div_start = (state_reg == S_DIV_START);

    icu_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (opa_reg),
        .divisor   (opb_reg),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // hand the result to the output register once it is free
    assign load_out = (state_reg == S_DONE) && (!out_valid_reg || rsp.ready);

    always_comb
    begin
        state_next = state_reg;
        opa_next   = opa_reg;
        opb_next   = opb_reg;
        res_next   = res_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_DONE;
                    opa_next   = a_in;
                    opb_next   = b_in;
                    case (op_t'(req.req_type))
                        OP_ADD: res_next = a_in + b_in;
                        OP_SUB: res_next = a_in - b_in;
                        OP_MUL: state_next = S_MUL;
                        OP_POW:
                        begin
                            res_next = W'(1);
                            // zero or negative exponent gives 1
                            if (!b_in[W-1] && b_in != '0)
                                state_next = S_POW_ACC;
                        end
                        OP_ABS: res_next = a_in[W-1] ? (W'(0) - a_in) : a_in;
                        OP_PRIME:
                        begin
                            res_next = '0;
                            opb_next = W'(2);
                            // negatives, 0 and 1 are not prime
                            if (!a_in[W-1] && a_in >= W'(2))
                                state_next = S_DIV_START;
                        end
                        default: res_next = '0;
                    endcase
                end
            end
            S_MUL:
            begin
                res_next   = mul_p;
                state_next = S_DONE;
            end
            S_POW_ACC:
            begin
                if (opb_reg == '0)
                    state_next = S_DONE;
                else
                begin
                    if (opb_reg[0])
                        res_next = mul_p;
                    state_next = S_POW_SQR;
                end
            end
            S_POW_SQR:
            begin
                opa_next   = mul_p;
                opb_next   = opb_reg >> 1;
                state_next = S_POW_ACC;
            end
            S_DIV_START:
            begin
                state_next = S_DIV_WAIT;
            end
            S_DIV_WAIT:
            begin
                if (div_done)
                begin
                    if (opb_reg > div_quo)
                    begin
                        // divisor passed the square root: prime
                        res_next   = W'(1);
                        state_next = S_DONE;
                    end
                    else if (div_rem == '0)
                    begin
                        res_next   = '0;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        opb_next   = opb_reg + W'(1);
                        state_next = S_DIV_START;
                    end
                end
            end
            S_DONE:
            begin
                if (load_out)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_data_next  = res_reg;
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        opa_reg      <= opa_next;
        opb_reg      <= opb_next;
        res_reg      <= res_next;
        out_data_reg <= out_data_next;
    end

    assign req.ready  = (state_reg == S_IDLE);
    assign rsp.valid  = out_valid_reg;
    assign rsp.answer = out_data_reg;

endmodule

FILE: hw/rtl/icu_divider.sv
module icu_divider (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [icu_pkg::DATA_WIDTH-1:0]  dividend,
    input  logic [icu_pkg::DATA_WIDTH-1:0]  divisor,
    output logic                            done,
    output logic [icu_pkg::DATA_WIDTH-1:0]  quotient,
    output logic [icu_pkg::DATA_WIDTH-1:0]  remainder
);
    import icu_pkg::*;

    localparam int W = DATA_WIDTH;

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [W-1:0]         rem_reg;
    logic [W-1:0]         quo_reg;
    logic [W-1:0]         den_reg;

    logic [W:0]           shifted;
    logic [W:0]           diff;
    logic                 fits;
    logic [W-1:0]         rem_step;

    // restoring step: one quotient bit per cycle
    always_comb
    begin
        shifted  = {rem_reg, quo_reg[W-1]};
        diff     = shifted - {1'b0, den_reg};
        fits     = ~diff[W];
        rem_step = fits ? diff[W-1:0] : shifted[W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + DIV_CNT_W'(1);
                if (cnt_reg == DIV_CNT_W'(W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            den_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_step;
            quo_reg <= {quo_reg[W-2:0], fits};
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

FILE: tb/sv/integer_calculator_unit_tb.sv
`timescale 1ns / 1ps

module integer_calculator_unit_tb;

    import icu_pkg::*;

    typedef logic signed [DATA_WIDTH-1:0] word_t;
    typedef logic [REQ_TYPE_W-1:0]        code_t;

    // Codes with no operation behind them; the block answers zero.
    localparam code_t OP_SPARE_LO = 3'd6;
    localparam code_t OP_SPARE_HI = 3'd7;

    localparam word_t WORD_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    localparam word_t WORD_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};

    localparam int RANDOM_REQS  = 76;
    localparam int DRAIN_CYCLES = 100;
    // Slowest correct run: the directed prime near 2^24 (~4096 divisors) plus
    // a few random prime tests up to 2^22 dominate the run time, and this
    // limit leaves ample margin over them and everything else, idle gaps included.
    localparam int CYCLE_LIMIT  = 3_000_000;

    typedef struct {
        code_t kind;
        word_t a;
        word_t b;
    } calc_req_t;

    typedef struct {
        calc_req_t req;
        word_t     answer;
    } answer_due_t;

    logic clk;
    logic rst_n;

    icu_req_if req_bus ();
    icu_rsp_if rsp_bus ();

    integer_calculator_unit u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .rsp   (rsp_bus)
    );

    calc_req_t   pending_reqs[$];
    answer_due_t answers_due[$];

    int mismatch_count;
    int accepted_count;
    int answers_seen;
    int directed_count;
    int cycle_count;
    int op_seen[8];

    // Idle bookkeeping, one set per side.
    int send_gap;
    int send_burst;
    int take_stall;
    int take_burst;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Answer predictor: what the calculator must return for one request.
    // ------------------------------------------------------------------

    // Trial division by every d with d*d <= v; anything below two, negative
    // values included, is not prime.
    function automatic word_t prime_answer(word_t v);
        longint unsigned n;
        longint unsigned d;
        if (v[DATA_WIDTH-1] || v < 2)
            return '0;
        n = longint'(unsigned'(v));
        for (d = 2; d <= n / d; d++)
        begin
            if (n % d == 0)
                return '0;
        end
        return word_t'(1);
    endfunction

    // Square and multiply, wrapping at the word width; a zero or negative
    // exponent gives one.
    function automatic word_t power_answer(word_t base_in, word_t expo_in);
        logic [DATA_WIDTH-1:0] base_v;
        logic [DATA_WIDTH-1:0] expo_v;
        logic [DATA_WIDTH-1:0] acc_v;
        if (expo_in[DATA_WIDTH-1])
            return word_t'(1);
        base_v = base_in;
        expo_v = expo_in;
        acc_v  = 1;
        while (expo_v != 0)
        begin
            if (expo_v[0])
                acc_v = acc_v * base_v;
            base_v = base_v * base_v;
            expo_v = expo_v >> 1;
        end
        return word_t'(acc_v);
    endfunction

    function automatic word_t calc_answer(calc_req_t r);
        word_t res;
        case (r.kind)
            OP_ADD:   res = r.a + r.b;
            OP_SUB:   res = r.a - r.b;
            OP_MUL:   res = r.a * r.b;
            OP_POW:   res = power_answer(r.a, r.b);
            // The most negative value wraps onto itself.
            OP_ABS:   res = r.a[DATA_WIDTH-1] ? word_t'(0) - r.a : r.a;
            OP_PRIME: res = prime_answer(r.a);
            default:  res = '0;
        endcase
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    task automatic queue_req(code_t kind, word_t a, word_t b);
        calc_req_t r;
        r.kind = kind;
        r.a    = a;
        r.b    = b;
        pending_reqs.push_back(r);
    endtask

    function automatic word_t pick_operand();
        case ($urandom_range(0, 4))
            0: return word_t'($urandom_range(0, 32)) - word_t'(16);
            1:
            begin
                case ($urandom_range(0, 4))
                    0: return WORD_MIN;
                    1: return WORD_MAX;
                    2: return '0;
                    3: return '1;
                    default: return word_t'(1);
                endcase
            end
            default: return word_t'($urandom);
        endcase
    endfunction

    // Keep exponents mostly short so the loop count stays varied but the
    // upper bits still flip from the full-range draws.
    function automatic word_t pick_exponent();
        case ($urandom_range(0, 5))
            4: return word_t'($urandom);
            5: return word_t'(0) - word_t'($urandom_range(1, 8));
            default: return word_t'($urandom_range(0, 40));
        endcase
    endfunction

    // Large odd values may be prime and cost ~sqrt(a) divider passes, so hold
    // them below 2^22; full-width draws are forced even or negative.
    function automatic word_t pick_prime_candidate();
        case ($urandom_range(0, 9))
            5: return word_t'($urandom_range(0, 40)) - word_t'(8);
            6: return word_t'($urandom_range(3, 255) * $urandom_range(3, 255));
            7: return word_t'($urandom_range(0, 4194303));
            8: return word_t'($urandom | 32'h8000_0000);
            9: return word_t'($urandom & 32'hFFFF_FFFE);
            default: return word_t'($urandom_range(2, 65535) | 1);
        endcase
    endfunction

    function automatic calc_req_t pick_random_req();
        calc_req_t r;
        int roll;
        roll = $urandom_range(0, 49);
        if (roll < 48)
            r.kind = code_t'(roll % 6);
        else if (roll == 48)
            r.kind = OP_SPARE_LO;
        else
            r.kind = OP_SPARE_HI;
        r.a = pick_operand();
        r.b = pick_operand();
        if (r.kind == OP_POW)
            r.b = pick_exponent();
        else if (r.kind == OP_PRIME)
            r.a = pick_prime_candidate();
        return r;
    endfunction

    // Idle length: mostly none or short, a few long, and now and then a
    // stretch of back-to-back cycles with no idling at all.
    function automatic int pick_idle(ref int burst_left);
        int roll;
        if (burst_left > 0)
        begin
            burst_left--;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 8)
        begin
            burst_left = $urandom_range(8, 24);
            return 0;
        end
        if (roll < 55)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 4);
        return $urandom_range(12, 40);
    endfunction

    task automatic report_mismatch(string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------
    // Request driver: advance through the pending queue, one beat at a time.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : drive_requests
        calc_req_t next_req;
        calc_req_t sent_req;
        answer_due_t due;
        if (!rst_n)
        begin
            req_bus.valid <= 1'b0;
            send_gap = 0;
        end
        else
        begin
            // Accepted beat: predict its answer from the values on the bus.
            if (req_bus.valid && req_bus.ready)
            begin
                sent_req.kind = req_bus.req_type;
                sent_req.a    = req_bus.operand_a;
                sent_req.b    = req_bus.operand_b;
                due.req       = sent_req;
                due.answer    = calc_answer(sent_req);
                answers_due.push_back(due);
                op_seen[sent_req.kind]++;
                accepted_count++;
            end
            // Hold the beat while the block is busy; otherwise idle or load.
            if (!req_bus.valid || req_bus.ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    req_bus.valid <= 1'b0;
                end
                else if (pending_reqs.size() != 0)
                begin
                    next_req = pending_reqs.pop_front();
                    req_bus.req_type  <= next_req.kind;
                    req_bus.operand_a <= next_req.a;
                    req_bus.operand_b <= next_req.b;
                    req_bus.valid     <= 1'b1;
                    send_gap = pick_idle(send_burst);
                end
                else
                begin
                    req_bus.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Answer monitor: check each beat against the oldest prediction and
    // stall ready at random.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : check_answers
        answer_due_t due;
        if (!rst_n)
        begin
            rsp_bus.ready <= 1'b0;
            take_stall = 0;
        end
        else
        begin
            if (rsp_bus.valid && rsp_bus.ready)
            begin
                answers_seen++;
                if (answers_due.size() == 0)
                begin
                    report_mismatch($sformatf("answer %0d with no request outstanding",
                                              rsp_bus.answer));
                end
                else
                begin
                    due = answers_due.pop_front();
                    if (rsp_bus.answer !== due.answer)
                        report_mismatch($sformatf(
                            "op %0d a=%0d b=%0d: answer %0d, expected %0d",
                            due.req.kind, due.req.a, due.req.b,
                            rsp_bus.answer, due.answer));
                end
            end
            // Start a stall now and then; drop ready for its length.
            if (take_stall == 0 && $urandom_range(0, 3) == 0)
                take_stall = pick_idle(take_burst);
            if (take_stall > 0)
            begin
                take_stall--;
                rsp_bus.ready <= 1'b0;
            end
            else
            begin
                rsp_bus.ready <= 1'b1;
            end
        end
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d answers still due",
                     cycle_count, answers_due.size());
            $display("FAILURE");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequence: directed corners, then random requests, then drain.
    // ------------------------------------------------------------------
    initial
    begin
        int i;
        // Known values on every block input from time zero.
        rst_n             = 1'b0;
        req_bus.valid     = 1'b0;
        req_bus.req_type  = OP_ADD;
        req_bus.operand_a = '0;
        req_bus.operand_b = '0;
        rsp_bus.ready     = 1'b0;

        // Wrap-around at both ends for add, subtract and multiply.
        queue_req(OP_ADD, WORD_MAX, word_t'(1));
        queue_req(OP_ADD, WORD_MIN, WORD_MIN);
        queue_req(OP_ADD, '1, '1);
        queue_req(OP_SUB, WORD_MIN, word_t'(1));
        queue_req(OP_SUB, '0, WORD_MIN);
        queue_req(OP_MUL, WORD_MAX, WORD_MAX);
        queue_req(OP_MUL, '1, WORD_MIN);
        // Power: zero and negative exponents give one; a huge exponent
        // runs the full squaring chain; a negative base reaches the most negative value.
        queue_req(OP_POW, word_t'(3), '0);
        queue_req(OP_POW, word_t'(5), '1);
        queue_req(OP_POW, '0, '0);
        queue_req(OP_POW, word_t'(3), WORD_MAX);
        queue_req(OP_POW, word_t'(-2), word_t'(31));
        // Absolute value, the most negative value wrapping onto itself.
        queue_req(OP_ABS, WORD_MIN, WORD_MAX);
        queue_req(OP_ABS, word_t'(-7), '0);
        // Prime test: two, below two, negative, a square, a large even value and
        // the largest prime under 2^24.
        queue_req(OP_PRIME, word_t'(2), '0);
        queue_req(OP_PRIME, word_t'(1), '0);
        queue_req(OP_PRIME, '0, '0);
        queue_req(OP_PRIME, word_t'(-7), '0);
        queue_req(OP_PRIME, WORD_MIN, '0);
        queue_req(OP_PRIME, word_t'(25), '0);
        queue_req(OP_PRIME, word_t'(2147483646), '0);
        queue_req(OP_PRIME, word_t'(16777213), WORD_MAX);
        // Spare codes answer zero whatever the operands.
        queue_req(OP_SPARE_LO, WORD_MAX, '1);
        queue_req(OP_SPARE_HI, '1, WORD_MIN);
        directed_count = pending_reqs.size();

        for (i = 0; i < RANDOM_REQS; i++)
            pending_reqs.push_back(pick_random_req());

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Wait for the last request beat, then for every answer.
        while (pending_reqs.size() != 0 || req_bus.valid)
            @(posedge clk);
        while (answers_due.size() != 0)
            @(posedge clk);
        // Leave room for any stray answer beat to show up.
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d requests (%0d directed corners, %0d random), checked %0d answers.",
                 accepted_count, directed_count, accepted_count - directed_count,
                 answers_seen);
        $display("Per operation: add %0d sub %0d mul %0d pow %0d abs %0d prime %0d spare %0d",
                 op_seen[OP_ADD], op_seen[OP_SUB], op_seen[OP_MUL], op_seen[OP_POW],
                 op_seen[OP_ABS], op_seen[OP_PRIME],
                 op_seen[OP_SPARE_LO] + op_seen[OP_SPARE_HI]);
        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/icu_pkg.sv
hw/rtl/icu_req_if.sv
hw/rtl/icu_rsp_if.sv
hw/rtl/icu_divider.sv
hw/rtl/integer_calculator_unit.sv
tb/sv/integer_calculator_unit_tb.sv
